FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define ASSERT_IMPLIES(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication, clocked on clk, quiet during reset
`define ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: design/empq_pkg.sv
package empq_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int KEY_W         = 164;
    localparam int COUNT_OUT_W   = 7;
    localparam int IN_TDATA_W    = 168;
    localparam int OUT_TDATA_W   = 176;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT_RD,
        ST_ROOT,
        ST_UP_RD,
        ST_UP,
        ST_DN_RD,
        ST_DN_SEL,
        ST_DN,
        ST_DONE
    } state_t;

    // most significant field first, so a plain unsigned compare gives the queue order
    typedef struct packed {
        logic [63:0] evt_time;
        logic [63:0] tie_value;
        logic [31:0] user_id;
        logic [3:0]  evt_type;
    } key_t;

    typedef struct packed {
        err_t err;
        key_t head;
    } res_t;

endpackage

FILE: design/empq_mem.sv
module empq_mem #(
    parameter int DEPTH = empq_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int W     = empq_pkg::KEY_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [W-1:0]  rd_data_a,
    output logic [W-1:0]  rd_data_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: design/empq_cmp.sv
module empq_cmp (
    input  empq_pkg::key_t a,
    input  empq_pkg::key_t b,
    output logic           lt
);

    // time, tie value, user id, type in that order of weight
    assign lt = (a.evt_time != b.evt_time)   ? (a.evt_time < b.evt_time) :
                (a.tie_value != b.tie_value) ? (a.tie_value < b.tie_value) :
                (a.user_id != b.user_id)     ? (a.user_id < b.user_id) :
                                               (a.evt_type < b.evt_type);

endmodule

FILE: design/empq_ctrl.sv
`include "assert_macros.svh"

module empq_ctrl #(
    parameter int QUEUE_DEPTH = empq_pkg::DEFAULT_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  empq_pkg::mode_t       mode,
    input  empq_pkg::key_t        in_key,
    output logic                  res_valid,
    input  logic                  res_ready,
    output empq_pkg::res_t        res,
    output logic [CNT_W-1:0]      count,
    output logic                  mem_we,
    output logic [AW-1:0]         wr_addr,
    output empq_pkg::key_t        wr_data,
    output logic [AW-1:0]         rd_addr_a,
    output logic [AW-1:0]         rd_addr_b,
    input  empq_pkg::key_t        rd_data_a,
    input  empq_pkg::key_t        rd_data_b,
    output empq_pkg::key_t        cmp_a,
    output empq_pkg::key_t        cmp_b,
    input  logic                  cmp_lt
);

    localparam int IW = AW + 2;

    empq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    cidx_reg, cidx_next;
    logic             pop_reg, pop_next;
    empq_pkg::key_t   key_reg, key_next;
    empq_pkg::key_t   child_reg, child_next;
    empq_pkg::res_t   res_reg, res_next;

    logic [IW-1:0]    l_idx;
    logic [IW-1:0]    r_idx;
    logic             l_ok;
    logic             r_ok;
    logic [AW-1:0]    cur_m1;
    logic [AW-1:0]    parent;
    logic [CNT_W-1:0] cnt_m1;

    assign l_idx  = {1'b0, cur_reg, 1'b1};
    assign r_idx  = l_idx + IW'(1);
    assign l_ok   = l_idx < IW'(cnt_reg);
    assign r_ok   = r_idx < IW'(cnt_reg);
    assign cur_m1 = cur_reg - AW'(1);
    assign parent = cur_m1 >> 1;
    assign cnt_m1 = cnt_reg - CNT_W'(1);

    assign res   = res_reg;
    assign count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= empq_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        cidx_reg  <= cidx_next;
        pop_reg   <= pop_next;
        key_reg   <= key_next;
        child_reg <= child_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        cidx_next  = cidx_reg;
        pop_next   = pop_reg;
        key_next   = key_reg;
        child_next = child_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = cur_reg;
        wr_data    = key_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        cmp_a      = key_reg;
        cmp_b      = rd_data_a;

        case (state_reg)
            empq_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    res_next.err  = empq_pkg::ERR_OK;
                    res_next.head = '0;
                    pop_next      = (mode == empq_pkg::MODE_POP);
                    case (mode)
                        empq_pkg::MODE_PUSH:
                        begin
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_next.err = empq_pkg::ERR_FULL;
                                state_next   = empq_pkg::ST_DONE;
                            end
                            else
                            begin
                                key_next   = in_key;
                                cur_next   = cnt_reg[AW-1:0];
                                cnt_next   = cnt_reg + CNT_W'(1);
                                state_next = empq_pkg::ST_UP_RD;
                            end
                        end
                        empq_pkg::MODE_POP, empq_pkg::MODE_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.err = empq_pkg::ERR_EMPTY;
                                state_next   = empq_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = empq_pkg::ST_ROOT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = empq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // root and last entry are fetched together
            empq_pkg::ST_ROOT_RD:
            begin
                rd_addr_a  = '0;
                rd_addr_b  = cnt_m1[AW-1:0];
                state_next = empq_pkg::ST_ROOT;
            end

            empq_pkg::ST_ROOT:
            begin
                res_next.head = rd_data_a;
                if (pop_reg)
                begin
                    key_next   = rd_data_b;
                    cnt_next   = cnt_m1;
                    cur_next   = '0;
                    state_next = (cnt_m1 == '0) ? empq_pkg::ST_DONE : empq_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = empq_pkg::ST_DONE;
                end
            end

            empq_pkg::ST_UP_RD:
            begin
                if (cur_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = empq_pkg::ST_DONE;
                end
                else
                begin
                    rd_addr_a  = parent;
                    state_next = empq_pkg::ST_UP;
                end
            end

            // new key against its parent: move the parent down or settle
            empq_pkg::ST_UP:
            begin
                cmp_a  = key_reg;
                cmp_b  = rd_data_a;
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    wr_data    = rd_data_a;
                    cur_next   = parent;
                    state_next = empq_pkg::ST_UP_RD;
                end
                else
                begin
                    state_next = empq_pkg::ST_DONE;
                end
            end

            empq_pkg::ST_DN_RD:
            begin
                rd_addr_a  = l_idx[AW-1:0];
                rd_addr_b  = r_idx[AW-1:0];
                state_next = empq_pkg::ST_DN_SEL;
            end

            // pick the smaller child (left on a tie), or write the key here when there is no child
            empq_pkg::ST_DN_SEL:
            begin
                cmp_a = rd_data_b;
                cmp_b = rd_data_a;
                if (!l_ok)
                begin
                    mem_we     = 1'b1;
                    state_next = empq_pkg::ST_DONE;
                end
                else if (r_ok && cmp_lt)
                begin
                    child_next = rd_data_b;
                    cidx_next  = r_idx[AW-1:0];
                    state_next = empq_pkg::ST_DN;
                end
                else
                begin
                    child_next = rd_data_a;
                    cidx_next  = l_idx[AW-1:0];
                    state_next = empq_pkg::ST_DN;
                end
            end

            empq_pkg::ST_DN:
            begin
                cmp_a  = child_reg;
                cmp_b  = key_reg;
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    wr_data    = child_reg;
                    cur_next   = cidx_reg;
                    state_next = empq_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = empq_pkg::ST_DONE;
                end
            end

            empq_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = empq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = empq_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_wr_in_range, mem_we, IW'(wr_addr) < IW'(cnt_reg))
    `ASSERT_IMPLIES(a_full_err, res_valid && res_reg.err == empq_pkg::ERR_FULL, cnt_reg == CNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_push_count, s_valid && s_ready && mode == empq_pkg::MODE_PUSH && cnt_reg != CNT_W'(QUEUE_DEPTH), cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `ASSERT_NEXT(a_pop_count, state_reg == empq_pkg::ST_ROOT && pop_reg, cnt_reg == $past(cnt_reg) - CNT_W'(1))
    `ASSERT_IMPLIES(a_root_nonempty, state_reg == empq_pkg::ST_ROOT_RD, cnt_reg != '0)

endmodule

FILE: design/event_min_priority_queue_top.sv
// bounded min-priority queue of events, kept as a binary heap in one memory
// input channel s_axis: tuser carries the mode (push, pop, peek), tdata the
//   event to push (ignored for pop and peek)
// output channel m_axis: one item per input item with error code, head event
//   (zero unless a pop or peek succeeded), count after the operation, empty flag
// order: earliest time, then tie value, then user id, then type
// steps: an error or an unused mode goes straight to the result; a peek reads
//   the root; a pop reads the root and the last entry together, then moves each
//   smaller child up from the root and writes the last entry where it settles;
//   a push moves each larger parent down and writes the key where it settles;
//   the key crosses at most log2 depth heap levels
// one item at a time; s_axis_tready is high only while the sequencer is idle
// the walk is paced by the single key comparator and the one memory write port
// a result sits in the output register until taken; a stalled m_axis holds the
//   sequencer at its last step, so no item is lost
// reset empties the queue at once; the heap memory itself is not cleared
module event_min_priority_queue_top #(
    parameter int QUEUE_DEPTH = empq_pkg::DEFAULT_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // event_time, tie_breaker, user_id, event_type, zero pad
    input  logic [empq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // error_code, head_time, head_tie_breaker, head_user_id, head_event_type,
    // entry_count, is_empty, zero pad
    output logic [empq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = empq_pkg::COUNT_OUT_W;

    empq_pkg::key_t   in_key;
    empq_pkg::res_t   res;
    logic             res_valid;
    logic             res_ready;
    logic [CNT_W-1:0] count;
    logic [CNT_W+CW-1:0] count_ext;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    empq_pkg::key_t   wr_data;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;
    empq_pkg::key_t   rd_data_a;
    empq_pkg::key_t   rd_data_b;
    empq_pkg::key_t   cmp_a;
    empq_pkg::key_t   cmp_b;
    logic             cmp_lt;

    logic                             m_tvalid_reg;
    logic [empq_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [empq_pkg::OUT_TDATA_W-1:0] m_tdata_next;

    assign in_key.evt_time  = s_axis_tdata[63:0];
    assign in_key.tie_value = s_axis_tdata[127:64];
    assign in_key.user_id   = s_axis_tdata[159:128];
    assign in_key.evt_type  = s_axis_tdata[163:160];

    empq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .W     (empq_pkg::KEY_W)
    ) u_mem (
        .clk       (clk),
        .we        (mem_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    empq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    empq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .mode      (empq_pkg::mode_t'(s_axis_tuser)),
        .in_key    (in_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count),
        .mem_we    (mem_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_lt    (cmp_lt)
    );

    // count reported modulo 128
    assign count_ext = {{CW{1'b0}}, count};

    assign m_tdata_next = {2'b00,
                           (count == '0),
                           count_ext[CW-1:0],
                           res.head.evt_type,
                           res.head.user_id,
                           res.head.tie_value,
                           res.head.evt_time,
                           res.err};

    assign res_ready = !m_tvalid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule
